/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared shorthand for concurrent checks on i_clk, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/qvr_pkg.sv */
// ----------------------------------------------------------------------------
// qvr_pkg
// shared types and constants of the quaternion vector rotation core
// ----------------------------------------------------------------------------
package qvr_pkg;

    // width of one rotated vector component
    localparam int OUT_WIDTH = 18;

    typedef logic signed [OUT_WIDTH-1:0] t_rot;

    // load enables of the two register stages inside a split multiplier
    typedef struct packed {
        logic load_part;
        logic load_sum;
    } t_mul_en;

endpackage

/* design/qvr_in_if.sv */
// ----------------------------------------------------------------------------
// qvr_in_if
// input channel: one quaternion and one vector per item, valid/ready
// ----------------------------------------------------------------------------
interface qvr_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w;
    logic signed [DATA_WIDTH-1:0] quat_x;
    logic signed [DATA_WIDTH-1:0] quat_y;
    logic signed [DATA_WIDTH-1:0] quat_z;
    logic signed [DATA_WIDTH-1:0] vec_x;
    logic signed [DATA_WIDTH-1:0] vec_y;
    logic signed [DATA_WIDTH-1:0] vec_z;

    modport source (
        output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        input  ready
    );

    modport sink (
        input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z,
        output ready
    );
endinterface

/* design/qvr_out_if.sv */
// ----------------------------------------------------------------------------
// qvr_out_if
// result channel: one rotated vector per item, valid/ready
// ----------------------------------------------------------------------------
interface qvr_out_if;
    import qvr_pkg::*;

    logic valid;
    logic ready;
    t_rot rot_x;
    t_rot rot_y;
    t_rot rot_z;

    modport source (
        output valid, rot_x, rot_y, rot_z,
        input  ready
    );

    modport sink (
        input  valid, rot_x, rot_y, rot_z,
        output ready
    );
endinterface

/* design/qvr_split_mul.sv */
// ----------------------------------------------------------------------------
// qvr_split_mul
// two-stage multiply of a wide signed partial product by a quaternion
// component: the wide operand is split in halves, each half is multiplied
// and registered, then the halves are recombined and registered
// ----------------------------------------------------------------------------
module qvr_split_mul #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                           i_clk,
    input  qvr_pkg::t_mul_en               i_en,
    input  logic signed [2*DATA_WIDTH+1:0] i_p,
    input  logic signed [DATA_WIDTH-1:0]   i_q,
    output logic signed [3*DATA_WIDTH+1:0] o_prod
);
    import qvr_pkg::*;

    localparam int PW  = 2 * DATA_WIDTH + 2;  // wide operand
    localparam int LW  = DATA_WIDTH + 1;      // low half, unsigned
    localparam int PRW = 3 * DATA_WIDTH + 2;  // full product

    logic signed [LW+DATA_WIDTH:0]        r_lo_prod;
    logic signed [PW-LW+DATA_WIDTH-1:0]   r_hi_prod;
    logic signed [PRW-1:0]                r_prod;

    // partial products of the two halves
    always_ff @(posedge i_clk) begin
        if (i_en.load_part) begin
            r_lo_prod <= $signed({1'b0, i_p[LW-1:0]}) * i_q;
            r_hi_prod <= $signed(i_p[PW-1:LW]) * i_q;
        end
    end

    // recombine: high half weighted by the width of the low half
    always_ff @(posedge i_clk) begin
        if (i_en.load_sum) begin
            r_prod <= (PRW'(r_hi_prod) <<< LW) + PRW'(r_lo_prod);
        end
    end

    assign o_prod = r_prod;

endmodule

/* design/quaternion_vector_rotation_core.sv */
// ----------------------------------------------------------------------------
// quaternion_vector_rotation_core
// rotates a signed integer 3-vector by a fixed-point quaternion, q v q*
// ----------------------------------------------------------------------------
// Each item carries a quaternion with DATA_WIDTH-2 fraction bits and a
// vector of signed integers; the result is the rotated vector, rounded once
// (half toward plus infinity) and saturated to 18 bits. The quaternion is
// used as given, so a non-unit q scales the result by |q|^2. The core is a
// six-stage pipeline: twelve quaternion-by-vector products, their sums into
// q*v, twelve split multiplies by conj(q) over two stages, the per-axis sum,
// then rounding and saturation into the output register. It takes one item
// every cycle, and each stage refills as soon as the one after it moves on,
// so a stall on the result side only halts input once every stage holds an
// item. Sums above 64 bits wrap modulo 2^64, which is exact up to a
// DATA_WIDTH of 19.
// ----------------------------------------------------------------------------
module quaternion_vector_rotation_core #(
    parameter int DATA_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qvr_in_if.sink           i_item,
    qvr_out_if.source        o_result
);
    import qvr_pkg::*;

    `include "assert_macros.svh"

    localparam int NUM_STAGES = 6;
    localparam int MW  = 2 * DATA_WIDTH;      // quaternion-by-vector product
    localparam int PW  = 2 * DATA_WIDTH + 2;  // component of q*v
    localparam int PRW = 3 * DATA_WIDTH + 2;  // product with conj(q)
    localparam int SW  = (3 * DATA_WIDTH + 5 > 64) ? 64 : 3 * DATA_WIDTH + 5;
    localparam int SH  = 2 * (DATA_WIDTH - 2);

    localparam logic signed [SW-1:0] HALF   = {{(SW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
    localparam logic signed [SW-1:0] SAT_HI = SW'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    // second product terms: which q*v component and which q component,
    // three axes of four terms each, and which terms are subtracted
    localparam int P_SEL [12] = '{1, 0, 2, 3,  0, 1, 2, 3,  0, 1, 2, 3};
    localparam int Q_SEL [12] = '{0, 1, 3, 2,  2, 3, 0, 1,  3, 2, 1, 0};
    localparam logic [11:0] TERM_NEG = 12'b0011_1001_0110;

    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] stage_en;

    logic signed [DATA_WIDTH-1:0] r_q1 [4];
    logic signed [DATA_WIDTH-1:0] r_q2 [4];
    logic signed [MW-1:0]         r_m  [12];
    logic signed [PW-1:0]         r_p  [4];
    logic signed [PRW-1:0]        prod [12];
    logic signed [SW-1:0]         r_acc [3];
    logic signed [SW-1:0]         n_acc [3];
    t_rot                         r_rot [3];
    t_rot                         n_rot [3];
    t_mul_en                      mul_en;

    // a stage loads when it is empty or the next stage is moving on
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || o_result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_v[k] || stage_en[k+1];
        end
    end

    assign i_item.ready = stage_en[0] && i_rst_n;

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (stage_en[0]) begin
                r_v[0] <= i_item.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: quaternion-by-vector products
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_m[0]  <= i_item.quat_x * i_item.vec_x;
            r_m[1]  <= i_item.quat_y * i_item.vec_y;
            r_m[2]  <= i_item.quat_z * i_item.vec_z;
            r_m[3]  <= i_item.quat_w * i_item.vec_x;
            r_m[4]  <= i_item.quat_y * i_item.vec_z;
            r_m[5]  <= i_item.quat_z * i_item.vec_y;
            r_m[6]  <= i_item.quat_w * i_item.vec_y;
            r_m[7]  <= i_item.quat_x * i_item.vec_z;
            r_m[8]  <= i_item.quat_z * i_item.vec_x;
            r_m[9]  <= i_item.quat_w * i_item.vec_z;
            r_m[10] <= i_item.quat_x * i_item.vec_y;
            r_m[11] <= i_item.quat_y * i_item.vec_x;
            r_q1[0] <= i_item.quat_w;
            r_q1[1] <= i_item.quat_x;
            r_q1[2] <= i_item.quat_y;
            r_q1[3] <= i_item.quat_z;
        end
    end

    // stage 2: components of q * (0, v)
    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_p[0] <= -PW'(r_m[0]) - PW'(r_m[1]) - PW'(r_m[2]);
            r_p[1] <=  PW'(r_m[3]) + PW'(r_m[4]) - PW'(r_m[5]);
            r_p[2] <=  PW'(r_m[6]) - PW'(r_m[7]) + PW'(r_m[8]);
            r_p[3] <=  PW'(r_m[9]) + PW'(r_m[10]) - PW'(r_m[11]);
            r_q2   <= r_q1;
        end
    end

    // stages 3 and 4: products with the conjugate, split multipliers
    assign mul_en = '{load_part: stage_en[2], load_sum: stage_en[3]};

    for (genvar t = 0; t < 12; t++) begin : g_term
        qvr_split_mul #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_mul (
            .i_clk  (i_clk),
            .i_en   (mul_en),
            .i_p    (r_p[P_SEL[t]]),
            .i_q    (r_q2[Q_SEL[t]]),
            .o_prod (prod[t])
        );
    end

    // stage 5: signed sum of four terms per axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_acc[a] = '0;
            for (int j = 0; j < 4; j++) begin
                if (TERM_NEG[4*a+j]) begin
                    n_acc[a] = n_acc[a] - SW'(prod[4*a+j]);
                end else begin
                    n_acc[a] = n_acc[a] + SW'(prod[4*a+j]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_acc <= n_acc;
        end
    end

    // stage 6: round, drop the fraction bits, saturate
    always_comb begin
        logic signed [SW-1:0] rounded;
        logic signed [SW-1:0] scaled;
        for (int a = 0; a < 3; a++) begin
            rounded = r_acc[a] + HALF;
            scaled  = rounded >>> SH;
            if (scaled > SAT_HI) begin
                n_rot[a] = SAT_HI[OUT_WIDTH-1:0];
            end else if (scaled < SAT_LO) begin
                n_rot[a] = SAT_LO[OUT_WIDTH-1:0];
            end else begin
                n_rot[a] = scaled[OUT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[5]) begin
            r_rot <= n_rot;
        end
    end

    assign o_result.valid = r_v[NUM_STAGES-1];
    assign o_result.rot_x = r_rot[0];
    assign o_result.rot_y = r_rot[1];
    assign o_result.rot_z = r_rot[2];

    // checks on pipeline occupancy
    `ASSERT_IMP(a_empty_out_takes_item, !o_result.valid, i_item.ready,
                "input stalled with empty output stage")
    `ASSERT_NEXT(a_fill_count_up,
                 (i_item.valid && i_item.ready) && !(o_result.valid && o_result.ready),
                 $countones(r_v) == $past($countones(r_v)) + 1, "item lost on entry")
    `ASSERT_NEXT(a_fill_count_down,
                 !(i_item.valid && i_item.ready) && (o_result.valid && o_result.ready),
                 $countones(r_v) + 1 == $past($countones(r_v)),
                 "item lost or repeated in pipeline")

endmodule
